// ===== rtl/mp2r_pkg.sv =====
package mp2r_pkg;

   localparam int PIX_W = 32;
   localparam int TZ_W = $clog2(PIX_W);
   localparam int CHAN_W = 8;
   localparam int CFG_IDX_W = 3;
   localparam int CFG_DATA_W = 32;
   localparam int DEPTH_W = 6;

   // 510 * val + top stays below 2^(PIX_W + 9).
   localparam int NUM_W = PIX_W + 9;
   localparam int DEN_W = PIX_W + 1;

   // Lane latency: shift stage, numerator stage, one stage per quotient bit.
   localparam int LANE_LAT = 2 + CHAN_W;
   localparam int NUM_CHAN = 4;

   localparam logic [DEPTH_W-1:0] ALPHA_DEPTH_LIMIT = DEPTH_W'(24);
   localparam logic [CHAN_W-1:0] FULL_SCALE = '1;

   localparam logic [CFG_IDX_W-1:0] REG_RED = CFG_IDX_W'(0);
   localparam logic [CFG_IDX_W-1:0] REG_GREEN = CFG_IDX_W'(1);
   localparam logic [CFG_IDX_W-1:0] REG_BLUE = CFG_IDX_W'(2);
   localparam logic [CFG_IDX_W-1:0] REG_DEPTH = CFG_IDX_W'(3);
   localparam logic [CFG_IDX_W-1:0] REG_BPP = CFG_IDX_W'(4);

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [TZ_W-1:0] tz_type;
   typedef logic [CHAN_W-1:0] chan_type;

   function automatic tz_type trailing_zeros(input pix_type mask);
      tz_type result;
      result = '0;
      for (int i = PIX_W - 1; i >= 0; i--) begin
         if (mask[i]) begin
            result = TZ_W'(i);
         end
      end
      return result;
   endfunction

endpackage

// ===== rtl/mp2r_channels_if.sv =====
interface mp2r_req_if;
   logic valid;
   logic ready;
   logic [mp2r_pkg::PIX_W-1:0] pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink (input valid, input pixel_word, output ready);
endinterface

interface mp2r_rsp_if;
   logic valid;
   logic ready;
   logic [mp2r_pkg::CHAN_W-1:0] red_out;
   logic [mp2r_pkg::CHAN_W-1:0] green_out;
   logic [mp2r_pkg::CHAN_W-1:0] blue_out;
   logic [mp2r_pkg::CHAN_W-1:0] alpha_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output alpha_out, input ready);
   modport sink (input valid, input red_out, input green_out, input blue_out,
                 input alpha_out, output ready);
endinterface

// ===== rtl/mp2r_scale_lane.sv =====
module mp2r_scale_lane (
   input  logic                    clock,
   input  logic                    advance,
   input  mp2r_pkg::pix_type       pixel,
   input  mp2r_pkg::pix_type       mask,
   input  mp2r_pkg::tz_type        tz,
   output mp2r_pkg::chan_type      scaled
);

   localparam int NUM_W = mp2r_pkg::NUM_W;
   localparam int DEN_W = mp2r_pkg::DEN_W;
   localparam int CHAN_W = mp2r_pkg::CHAN_W;

   mp2r_pkg::pix_type top_ff;
   mp2r_pkg::pix_type val_ff;
   logic              zero_a_ff;

   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic              zero_b_ff;

   logic [NUM_W-1:0]  rem_ff [CHAN_W];
   logic [DEN_W-1:0]  dden_ff [CHAN_W];
   logic [CHAN_W-1:0] quo_ff [CHAN_W];
   logic              zero_d_ff [CHAN_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         top_ff <= mask >> tz;
         val_ff <= (pixel & mask) >> tz;
         zero_a_ff <= (mask == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= (NUM_W'(val_ff) << 9) - (NUM_W'(val_ff) << 1) + NUM_W'(top_ff);
         den_ff <= {top_ff, 1'b0};
         zero_b_ff <= zero_a_ff;
      end
   end

   for (genvar k = 0; k < CHAN_W; k++) begin : g_div
      localparam int BIT = CHAN_W - 1 - k;
      logic [NUM_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [CHAN_W-1:0] quo_prev;
      logic              zero_prev;
      logic [NUM_W:0]    trial;
      logic [NUM_W-1:0]  rem_in;
      logic [CHAN_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_prev = num_ff;
         assign den_prev = den_ff;
         assign quo_prev = '0;
         assign zero_prev = zero_b_ff;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = dden_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign zero_prev = zero_d_ff[k-1];
      end

      always_comb begin
         trial = {1'b0, rem_prev} - ((NUM_W + 1)'(den_prev) << BIT);
         rem_in = rem_prev;
         quo_in = quo_prev;
         if (!trial[NUM_W]) begin
            rem_in = trial[NUM_W-1:0];
            quo_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            dden_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
            zero_d_ff[k] <= zero_prev;
         end
      end
   end

   // A zero mask scales to zero.
   assign scaled = zero_d_ff[CHAN_W-1] ? '0 : quo_ff[CHAN_W-1];

endmodule

// ===== rtl/masked_pixel_to_rgba8.sv =====
// Channel  Direction  Signals                                     Moves
// req      in         valid, ready, pixel_word                    one request per pixel
// rsp      out        valid, ready, red/green/blue/alpha_out      one RGBA8 result
// csr      in         csr_we, csr_index, csr_wdata                register writes
//
// One request is accepted every cycle while results are taken. Most of the
// pipeline depth is the restoring divider, which resolves one quotient bit per
// stage in each lane.
// Reset is synchronous; it clears the pipeline valid bits and loads the default format into the registers.
// A stall on rsp freezes every stage together; nothing is dropped or repeated.
module masked_pixel_to_rgba8 (
   input  logic                                   clock,
   input  logic                                   reset,
   mp2r_req_if.sink                               req,
   mp2r_rsp_if.source                             rsp,
   input  logic                                   csr_we,
   input  logic [mp2r_pkg::CFG_IDX_W-1:0]         csr_index,
   input  logic [mp2r_pkg::CFG_DATA_W-1:0]        csr_wdata
);

   localparam int PIX_W = mp2r_pkg::PIX_W;
   localparam int DEPTH_W = mp2r_pkg::DEPTH_W;
   localparam int NCH = mp2r_pkg::NUM_CHAN;
   localparam int PIPE_DEPTH = 2 + mp2r_pkg::LANE_LAT + 1;

   mp2r_pkg::pix_type     red_mask_ff;
   mp2r_pkg::pix_type     green_mask_ff;
   mp2r_pkg::pix_type     blue_mask_ff;
   logic [DEPTH_W-1:0]    depth_ff;
   logic [DEPTH_W-1:0]    bpp_ff;

   logic                  advance;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;

   mp2r_pkg::pix_type     pixel_s1_ff;
   mp2r_pkg::pix_type     pixel_s2_ff;
   mp2r_pkg::pix_type     mask_s2_ff [NCH];
   mp2r_pkg::tz_type      tz_s2_ff [NCH];
   mp2r_pkg::pix_type     mask_in [NCH];
   mp2r_pkg::pix_type     pmask;
   mp2r_pkg::chan_type    scaled [NCH];

   mp2r_pkg::chan_type    red_ff;
   mp2r_pkg::chan_type    green_ff;
   mp2r_pkg::chan_type    blue_ff;
   mp2r_pkg::chan_type    alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_mask_ff <= 32'h00FF_0000;
         green_mask_ff <= 32'h0000_FF00;
         blue_mask_ff <= 32'h0000_00FF;
         depth_ff <= DEPTH_W'(24);
         bpp_ff <= DEPTH_W'(32);
      end else if (csr_we) begin
         case (csr_index)
            mp2r_pkg::REG_RED: red_mask_ff <= csr_wdata[PIX_W-1:0];
            mp2r_pkg::REG_GREEN: green_mask_ff <= csr_wdata[PIX_W-1:0];
            mp2r_pkg::REG_BLUE: blue_mask_ff <= csr_wdata[PIX_W-1:0];
            mp2r_pkg::REG_DEPTH: depth_ff <= csr_wdata[DEPTH_W-1:0];
            mp2r_pkg::REG_BPP: bpp_ff <= csr_wdata[DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance = !valid_ff[PIPE_DEPTH-1] || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      valid_in = {valid_ff[PIPE_DEPTH-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      if (bpp_ff >= DEPTH_W'(PIX_W)) begin
         pmask = '1;
      end else begin
         pmask = (PIX_W'(1) << bpp_ff[mp2r_pkg::TZ_W-1:0]) - PIX_W'(1);
      end
      mask_in[0] = red_mask_ff;
      mask_in[1] = green_mask_ff;
      mask_in[2] = blue_mask_ff;
      mask_in[3] = '0;
      if (depth_ff > mp2r_pkg::ALPHA_DEPTH_LIMIT) begin
         mask_in[3] = pmask & ~(red_mask_ff | green_mask_ff | blue_mask_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_s1_ff <= req.pixel_word;
         pixel_s2_ff <= pixel_s1_ff;
      end
   end

   for (genvar c = 0; c < NCH; c++) begin : g_lane
      always_ff @(posedge clock) begin
         if (advance) begin
            mask_s2_ff[c] <= mask_in[c];
            tz_s2_ff[c] <= mp2r_pkg::trailing_zeros(mask_in[c]);
         end
      end

      mp2r_scale_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .pixel   (pixel_s2_ff),
         .mask    (mask_s2_ff[c]),
         .tz      (tz_s2_ff[c]),
         .scaled  (scaled[c])
      );
   end

   // Missing alpha and alpha that reads zero both come out opaque.
   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff <= scaled[0];
         green_ff <= scaled[1];
         blue_ff <= scaled[2];
         alpha_ff <= (scaled[3] == '0) ? mp2r_pkg::FULL_SCALE : scaled[3];
      end
   end

   assign rsp.valid = valid_ff[PIPE_DEPTH-1];
   assign rsp.red_out = red_ff;
   assign rsp.green_out = green_ff;
   assign rsp.blue_out = blue_ff;
   assign rsp.alpha_out = alpha_ff;

endmodule

// ===== tb/masked_pixel_to_rgba8_tb.sv =====
`timescale 1ns / 100ps

module masked_pixel_to_rgba8_tb;

   localparam int DRAIN_CYCLES = mp2r_pkg::LANE_LAT + 8;
   localparam int HOLD_CYCLES = 100;
   localparam int PHASE_ITEMS = 40;
   localparam int MAX_PRINTS = 60;

   localparam int STALL_NONE = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_PERIODIC = 2;

   typedef struct packed {
      mp2r_pkg::chan_type red;
      mp2r_pkg::chan_type green;
      mp2r_pkg::chan_type blue;
      mp2r_pkg::chan_type alpha;
   } rgba_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [mp2r_pkg::CFG_IDX_W-1:0] csr_index;
   logic [mp2r_pkg::CFG_DATA_W-1:0] csr_wdata;

   mp2r_req_if req_ch();
   mp2r_rsp_if rsp_ch();

   masked_pixel_to_rgba8 DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mp2r_pkg::pix_type fmt_red;
   mp2r_pkg::pix_type fmt_green;
   mp2r_pkg::pix_type fmt_blue;
   logic [mp2r_pkg::DEPTH_W-1:0] fmt_depth;
   logic [mp2r_pkg::DEPTH_W-1:0] fmt_bpp;

   rgba_type rgba_expected[$];
   int error_count = 0;

   bit gaps_on = 1'b0;
   int burst_left = 0;
   int stall_mode = STALL_NONE;
   int stall_phase = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;

   always #5 clock = ~clock;

   function automatic mp2r_pkg::chan_type scale_field(input mp2r_pkg::pix_type pixel,
                                                      input mp2r_pkg::pix_type mask);
      logic [63:0] top;
      logic [63:0] level;
      logic [63:0] scaled;
      int sh;
      if (mask == '0) begin
         return '0;
      end
      sh = 0;
      while (!mask[sh]) begin
         sh++;
      end
      top = 64'(mask) >> sh;
      level = 64'(pixel & mask) >> sh;
      scaled = (level * 64'd510 + top) / (64'd2 * top);
      if (scaled > 64'd255) begin
         scaled = 64'd255;
      end
      return scaled[mp2r_pkg::CHAN_W-1:0];
   endfunction

   function automatic rgba_type unpack_pixel(input mp2r_pkg::pix_type pixel);
      logic [63:0] width_mask;
      mp2r_pkg::pix_type implied_alpha;
      rgba_type rgba;
      implied_alpha = '0;
      if (fmt_depth > mp2r_pkg::ALPHA_DEPTH_LIMIT) begin
         if (fmt_bpp >= mp2r_pkg::PIX_W) begin
            width_mask = {32'h0, 32'hFFFF_FFFF};
         end else begin
            width_mask = (64'd1 << fmt_bpp) - 64'd1;
         end
         implied_alpha = width_mask[mp2r_pkg::PIX_W-1:0] & ~(fmt_red | fmt_green | fmt_blue);
      end
      rgba.red = scale_field(pixel, fmt_red);
      rgba.green = scale_field(pixel, fmt_green);
      rgba.blue = scale_field(pixel, fmt_blue);
      rgba.alpha = mp2r_pkg::FULL_SCALE;
      if (implied_alpha != '0) begin
         rgba.alpha = scale_field(pixel, implied_alpha);
         if (rgba.alpha == '0) begin
            rgba.alpha = mp2r_pkg::FULL_SCALE;
         end
      end
      return rgba;
   endfunction

   function automatic mp2r_pkg::pix_type field_mask();
      int width;
      int pos;
      width = $urandom_range(1, 12);
      pos = $urandom_range(0, mp2r_pkg::PIX_W - width);
      return mp2r_pkg::PIX_W'(((64'd1 << width) - 64'd1) << pos);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_PRINTS) begin
         $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_NONE: begin
               rsp_ch.ready <= 1'b1;
            end
            STALL_RANDOM: begin
               rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_ch.ready <= ((stall_phase % 7) < 4);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      rgba_type want;
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (rgba_expected.size() == 0) begin
               report_mismatch("result with no request pending",
                               {rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out,
                                rsp_ch.alpha_out}, '0);
            end else begin
               want = rgba_expected.pop_front();
               if (rsp_ch.red_out !== want.red) begin
                  report_mismatch("red_out", 32'(rsp_ch.red_out), 32'(want.red));
               end
               if (rsp_ch.green_out !== want.green) begin
                  report_mismatch("green_out", 32'(rsp_ch.green_out), 32'(want.green));
               end
               if (rsp_ch.blue_out !== want.blue) begin
                  report_mismatch("blue_out", 32'(rsp_ch.blue_out), 32'(want.blue));
               end
               if (rsp_ch.alpha_out !== want.alpha) begin
                  report_mismatch("alpha_out", 32'(rsp_ch.alpha_out), 32'(want.alpha));
               end
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            rgba_expected.push_back(unpack_pixel(req_ch.pixel_word));
         end
      end
   end

   task automatic send_pixel(input mp2r_pkg::pix_type pixel);
      req_ch.valid <= 1'b1;
      req_ch.pixel_word <= pixel;
      do begin
         @(posedge clock);
      end while (req_ch.ready !== 1'b1);
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (rgba_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_format(input mp2r_pkg::pix_type red, input mp2r_pkg::pix_type green,
                             input mp2r_pkg::pix_type blue,
                             input logic [mp2r_pkg::DEPTH_W-1:0] depth,
                             input logic [mp2r_pkg::DEPTH_W-1:0] bpp);
      csr_we <= 1'b1;
      csr_index <= mp2r_pkg::REG_RED;
      csr_wdata <= red;
      @(posedge clock);
      csr_index <= mp2r_pkg::REG_GREEN;
      csr_wdata <= green;
      @(posedge clock);
      csr_index <= mp2r_pkg::REG_BLUE;
      csr_wdata <= blue;
      @(posedge clock);
      csr_index <= mp2r_pkg::REG_DEPTH;
      csr_wdata <= mp2r_pkg::CFG_DATA_W'(depth);
      @(posedge clock);
      csr_index <= mp2r_pkg::REG_BPP;
      csr_wdata <= mp2r_pkg::CFG_DATA_W'(bpp);
      @(posedge clock);
      csr_we <= 1'b0;
      fmt_red = red;
      fmt_green = green;
      fmt_blue = blue;
      fmt_depth = depth;
      fmt_bpp = bpp;
   endtask

   function automatic mp2r_pkg::pix_type random_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return $urandom & fmt_red;
         3: return $urandom | fmt_green;
         4: return $urandom & ~(fmt_red | fmt_green | fmt_blue);
         default: return $urandom;
      endcase
   endfunction

   // The reset format has no alpha, so every result carries full alpha.
   task automatic test_default_format();
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0012_3456);
      send_pixel(32'h8080_8080);
      send_pixel(32'h007F_8001);
      wait_idle();
   endtask

   task automatic test_alpha_channel();
      set_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 6'd32, 6'd32);
      send_pixel(32'hFF10_2030);
      send_pixel(32'h00AB_CDEF);
      send_pixel(32'h80FF_FFFF);
      send_pixel(32'h0100_0000);
      wait_idle();
   endtask

   task automatic test_special_masks();
      // The color masks fill all sixteen pixel bits, which leaves no alpha.
      set_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 6'd32, 6'd16);
      send_pixel(32'h0000_FFFF);
      send_pixel(32'h0000_8410);
      wait_idle();
      // An alpha of one in sixteen bits rounds to zero and is read as opaque.
      set_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 6'd25, 6'd32);
      send_pixel(32'h0001_0000);
      send_pixel(32'h7FFF_8000);
      wait_idle();
      set_format(32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 6'd32, 6'd0);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h7FFF_FFFE);
      wait_idle();
      set_format(32'hFFFF_FFFF, 32'h0F0F_0F0F, 32'hAAAA_AAAA, 6'd24, 6'd32);
      send_pixel(32'h8000_0000);
      send_pixel(32'h5555_5555);
      wait_idle();
      set_format(32'h0000_003F, 32'h0000_00C0, 32'h0000_0300, 6'd63, 6'd40);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0400);
      wait_idle();
      set_format(32'h0000_00FF, 32'h0000_FF00, 32'h0000_0000, 6'd26, 6'd20);
      send_pixel(32'h000F_0000);
      send_pixel(32'h0008_0000);
      wait_idle();
      set_format(32'h0000_00E0, 32'h0000_001C, 32'h0000_0003, 6'd1, 6'd8);
      send_pixel(32'h0000_00FF);
      send_pixel(32'h0000_0049);
      wait_idle();
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall requests.
   task automatic test_backpressure();
      gaps_on = 1'b0;
      stall_mode = STALL_NONE;
      set_format(32'h0000_03FF, 32'h000F_FC00, 32'h3FF0_0000, 6'd32, 6'd32);
      hold_asks <= hold_asks + 1;
      repeat (48) send_pixel(random_pixel());
      wait_idle();
   endtask

   task automatic test_random_formats();
      mp2r_pkg::pix_type red;
      mp2r_pkg::pix_type green;
      mp2r_pkg::pix_type blue;
      logic [mp2r_pkg::DEPTH_W-1:0] depth;
      logic [mp2r_pkg::DEPTH_W-1:0] bpp;
      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 3))
            0: begin
               case ($urandom_range(0, 3))
                  0: begin
                     red = 32'h0000_7C00;
                     green = 32'h0000_03E0;
                     blue = 32'h0000_001F;
                  end
                  1: begin
                     red = 32'h0000_00FF;
                     green = 32'h0000_FF00;
                     blue = 32'h00FF_0000;
                  end
                  2: begin
                     red = 32'h3FF0_0000;
                     green = 32'h000F_FC00;
                     blue = 32'h0000_03FF;
                  end
                  default: begin
                     red = 32'h0000_F800;
                     green = 32'h0000_07E0;
                     blue = 32'h0000_001F;
                  end
               endcase
            end
            1: begin
               red = field_mask();
               green = field_mask();
               blue = field_mask();
            end
            2: begin
               red = $urandom;
               green = $urandom;
               blue = $urandom;
            end
            default: begin
               red = ($urandom_range(0, 1) != 0) ? '0 : '1;
               green = field_mask();
               blue = ($urandom_range(0, 1) != 0) ? '0 : $urandom;
            end
         endcase
         case ($urandom_range(0, 3))
            0: depth = 6'd24;
            1: depth = 6'd32;
            2: depth = mp2r_pkg::DEPTH_W'($urandom_range(25, 32));
            default: depth = mp2r_pkg::DEPTH_W'($urandom_range(1, 24));
         endcase
         case ($urandom_range(0, 4))
            0: bpp = 6'd32;
            1: bpp = 6'd16;
            2: bpp = 6'd24;
            3: bpp = mp2r_pkg::DEPTH_W'($urandom_range(1, 32));
            default: bpp = ($urandom_range(0, 1) != 0) ? 6'd0
                                                        : mp2r_pkg::DEPTH_W'($urandom_range(33, 63));
         endcase
         set_format(red, green, blue, depth, bpp);
         if (phase == 0) begin
            stall_mode = STALL_NONE;
            gaps_on = 1'b0;
         end else begin
            stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            gaps_on = ($urandom_range(0, 1) != 0);
         end
         burst_left = $urandom_range(1, 12);
         repeat (PHASE_ITEMS) send_pixel(random_pixel());
         wait_idle();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = mp2r_pkg::REG_RED;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel_word = '0;
      rsp_ch.ready = 1'b0;
      fmt_red = 32'h00FF_0000;
      fmt_green = 32'h0000_FF00;
      fmt_blue = 32'h0000_00FF;
      fmt_depth = 6'd24;
      fmt_bpp = 6'd32;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      stall_mode = STALL_RANDOM;
      gaps_on = 1'b1;
      burst_left = 3;
      test_default_format();
      test_alpha_channel();
      test_special_masks();
      test_backpressure();
      test_random_formats();
      if (rgba_expected.size() != 0) begin
         report_mismatch("results never delivered", 32'(rgba_expected.size()), 32'd0);
      end
      if (error_count == 0) begin
         $display("masked_pixel_to_rgba8_tb: clean");
      end else begin
         $display("masked_pixel_to_rgba8_tb: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d results outstanding.", rgba_expected.size());
      $display("masked_pixel_to_rgba8_tb: errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mp2r_pkg.sv
rtl/mp2r_channels_if.sv
rtl/mp2r_scale_lane.sv
rtl/masked_pixel_to_rgba8.sv
tb/masked_pixel_to_rgba8_tb.sv
